FILE: sv/dlp_pkg.sv
// types, constants and helpers of the duration literal parser
package dlp_pkg;

	localparam longint unsigned UNITS_PER_SECOND = 64'd1000000000;
	localparam int MAX_LENGTH = 255;
	localparam int CNT_W = $clog2(MAX_LENGTH + 1);

	// unit factors split into a small multiple of a second and a second-based factor
	localparam longint unsigned K_MIN  = 64'd60;
	localparam longint unsigned K_HOUR = 64'd3600;
	localparam longint unsigned K_DAY  = 64'd86400;
	localparam longint unsigned F_NS   = UNITS_PER_SECOND / 64'd1000000000;
	localparam longint unsigned F_US   = UNITS_PER_SECOND / 64'd1000000;
	localparam longint unsigned F_MS   = UNITS_PER_SECOND / 64'd1000;

	localparam int STEPS = 3;

	typedef logic [2:0] unit_t;
	localparam unit_t UC_ONE = 3'd0;
	localparam unit_t UC_NS  = 3'd1;
	localparam unit_t UC_US  = 3'd2;
	localparam unit_t UC_MS  = 3'd3;
	localparam unit_t UC_S   = 3'd4;
	localparam unit_t UC_MIN = 3'd5;
	localparam unit_t UC_H   = 3'd6;
	localparam unit_t UC_D   = 3'd7;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UZ    = 8'h5a;
	localparam logic [7:0] CH_UNDER = 8'h5f;
	localparam logic [7:0] CH_D     = 8'h64;
	localparam logic [7:0] CH_E     = 8'h65;
	localparam logic [7:0] CH_H     = 8'h68;
	localparam logic [7:0] CH_I     = 8'h69;
	localparam logic [7:0] CH_L     = 8'h6c;
	localparam logic [7:0] CH_M     = 8'h6d;
	localparam logic [7:0] CH_N     = 8'h6e;
	localparam logic [7:0] CH_S     = 8'h73;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_U     = 8'h75;
	localparam logic [7:0] CASE_GAP = 8'h20;

	typedef enum logic [3:0] {
		PH_START, PH_L, PH_LT, PH_LTI, PH_LTIM, PH_HASH, PH_SIGN, PH_GFIRST,
		PH_GNEXT, PH_MWAIT, PH_NWAIT, PH_UWAIT, PH_PLEAD, PH_PSIGNED, PH_PDIG,
		PH_DONE
	} phase_t;

	typedef struct packed {
		logic [CNT_W-1:0] cnt;
		logic             fail;
		logic             zchk;
	} res_t;

	function automatic logic [7:0] to_lower(input logic [7:0] c);
		return (c >= CH_UA && c <= CH_UZ) ? c + CASE_GAP : c;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= CH_0 && c <= CH_9;
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic logic [CNT_W-1:0] cnt_inc(input logic [CNT_W-1:0] c);
		return (c < CNT_W'(MAX_LENGTH)) ? c + CNT_W'(1) : c;
	endfunction

endpackage

FILE: sv/duration_literal_parser.sv
// duration literal parser: character scanner, unit product pipeline and accumulator
// a zero byte passes the input register and stages s2 to s4 before the output register
// throughput: one character per cycle; the input stalls only while a result waits
//   for a full output register to drain
// unit products take two constant-multiply stages, then one add into the running total
// reset: arst_n clears the scanner state, all valid bits and the running total
module duration_literal_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_code
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // [63:0] time_value, [71:64] consumed_length
	output logic        m_tuser    // [0] parse_error
);
	import dlp_pkg::*;

	logic en;

	// input register
	logic       v_s1;
	logic [7:0] chr_s1;

	// scanner state
	phase_t           phase_q;
	logic [63:0]      pend_q;
	logic             dseen_q;
	unit_t            ucode_q;
	logic             neg_q;
	logic [CNT_W-1:0] cnt_q;
	logic             fail_q;
	logic             zchk_q;

	// scanner next values
	phase_t           ph;
	logic [63:0]      pend;
	logic             dseen;
	unit_t            ucode;
	logic             neg;
	logic [CNT_W-1:0] cnt;
	logic             fl;
	logic             zc;
	logic             stop;
	logic             do_add;
	unit_t            gcode;
	logic             addv;
	logic [63:0]      addp;
	unit_t            addc;
	logic             addn;
	logic [7:0]       c;
	logic [7:0]       lc;
	logic             eot;

	// product pipeline
	logic        grp_v_s2, grp_v_s3, grp_v_s4;
	logic [63:0] pend_s2, prod_s3, prod_s4;
	unit_t       code_s2, code_s3;
	logic        neg_s2, neg_s3, neg_s4;
	logic        res_v_s2, res_v_s3, res_v_s4;
	res_t        res_s2, res_s3, res_s4;
	logic [63:0] prod_a, prod_b;

	// accumulator and output
	logic [63:0] total_q;
	logic [63:0] sum;
	logic        res_fail;
	logic        out_v_q;
	logic [63:0] out_time_q;
	logic [7:0]  out_len_q;
	logic        out_err_q;

	assign en       = !(res_v_s4 && out_v_q && !m_tready);
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && s_tvalid) begin
			chr_s1 <= s_tdata;
		end
	end

	assign c   = chr_s1;
	assign lc  = to_lower(chr_s1);
	assign eot = v_s1 && (chr_s1 == CH_NUL);

	// one character may fall through up to three phases
	always_comb begin
		ph    = phase_q;
		pend  = pend_q;
		dseen = dseen_q;
		ucode = ucode_q;
		neg   = neg_q;
		cnt   = cnt_q;
		fl    = fail_q;
		zc    = zchk_q;
		stop  = 1'b0;
		addv  = 1'b0;
		addp  = '0;
		addc  = UC_ONE;
		addn  = 1'b0;
		do_add = 1'b0;
		gcode  = UC_ONE;
		for (int i = 0; i < STEPS; i++) begin
			do_add = 1'b0;
			gcode  = UC_ONE;
			if (v_s1 && !stop) begin
				stop = 1'b1;
				unique case (ph)
					PH_START: begin
						if (lc == CH_L) begin
							ph = PH_L;
						end else begin
							ph   = PH_PLEAD;
							stop = 1'b0;
						end
					end
					PH_L: begin
						if (lc == CH_T) begin
							cnt = CNT_W'(2);
							ph  = PH_LT;
						end else begin
							cnt = '0;
							ph  = PH_DONE;
						end
					end
					PH_LT: begin
						if (lc == CH_I) begin
							cnt = cnt_inc(cnt);
							ph  = PH_LTI;
						end else if (c == CH_HASH) begin
							cnt = cnt_inc(cnt);
							ph  = PH_SIGN;
						end else begin
							fl = 1'b1;
							ph = PH_DONE;
						end
					end
					PH_LTI: begin
						if (lc == CH_M) begin
							cnt = cnt_inc(cnt);
							ph  = PH_LTIM;
						end else begin
							fl = 1'b1;
							ph = PH_DONE;
						end
					end
					PH_LTIM: begin
						if (lc == CH_E) begin
							cnt = cnt_inc(cnt);
							ph  = PH_HASH;
						end else begin
							fl = 1'b1;
							ph = PH_DONE;
						end
					end
					PH_HASH: begin
						if (c == CH_HASH) begin
							cnt = cnt_inc(cnt);
							ph  = PH_SIGN;
						end else begin
							fl = 1'b1;
							ph = PH_DONE;
						end
					end
					PH_SIGN: begin
						ph = PH_GFIRST;
						if (c == CH_PLUS || c == CH_MINUS) begin
							neg = (c == CH_MINUS);
							cnt = cnt_inc(cnt);
						end else begin
							stop = 1'b0;
						end
					end
					PH_GNEXT: begin
						if (c == CH_NUL) begin
							ph = PH_DONE;
						end else begin
							ph   = PH_GFIRST;
							stop = 1'b0;
						end
					end
					PH_GFIRST: begin
						if (is_digit(c)) begin
							pend  = pend * 64'd10 + {56'd0, c - CH_0};
							dseen = 1'b1;
							cnt   = cnt_inc(cnt);
						end else begin
							unique case (lc)
								CH_D: begin
									cnt = cnt_inc(cnt); do_add = 1'b1; gcode = UC_D; ph = PH_GNEXT;
								end
								CH_H: begin
									cnt = cnt_inc(cnt); do_add = 1'b1; gcode = UC_H; ph = PH_GNEXT;
								end
								CH_S: begin
									cnt = cnt_inc(cnt); do_add = 1'b1; gcode = UC_S; ph = PH_GNEXT;
								end
								CH_M: begin
									cnt = cnt_inc(cnt); ph = PH_MWAIT;
								end
								CH_N: begin
									cnt = cnt_inc(cnt); ph = PH_NWAIT;
								end
								CH_U: begin
									cnt = cnt_inc(cnt); ph = PH_UWAIT;
								end
								CH_UNDER: begin
									cnt = cnt_inc(cnt); do_add = 1'b1; gcode = ucode; ph = PH_GNEXT;
								end
								default: begin
									// without digits the verdict waits for the final sum
									if (dseen) begin
										fl = 1'b1;
									end else begin
										zc = 1'b1;
									end
									ph = PH_DONE;
								end
							endcase
						end
					end
					PH_MWAIT: begin
						do_add = 1'b1;
						ph     = PH_GNEXT;
						if (lc == CH_S) begin
							cnt   = cnt_inc(cnt);
							gcode = UC_MS;
						end else begin
							gcode = UC_MIN;
							stop  = 1'b0;
						end
					end
					PH_NWAIT, PH_UWAIT: begin
						if (lc == CH_S) begin
							cnt    = cnt_inc(cnt);
							do_add = 1'b1;
							gcode  = (ph == PH_NWAIT) ? UC_NS : UC_US;
							ph     = PH_GNEXT;
						end else begin
							fl = 1'b1;
							ph = PH_DONE;
						end
					end
					PH_PLEAD: begin
						if (is_space(c)) begin
							cnt = cnt_inc(cnt);
						end else if (c == CH_PLUS || c == CH_MINUS) begin
							neg = (c == CH_MINUS);
							cnt = cnt_inc(cnt);
							ph  = PH_PSIGNED;
						end else begin
							ph   = PH_PSIGNED;
							stop = 1'b0;
						end
					end
					PH_PSIGNED, PH_PDIG: begin
						if (is_digit(c)) begin
							pend  = pend * 64'd10 + {56'd0, c - CH_0};
							dseen = 1'b1;
							cnt   = cnt_inc(cnt);
							ph    = PH_PDIG;
						end else begin
							if (dseen) begin
								do_add = 1'b1;
								gcode  = UC_ONE;
							end else begin
								cnt = '0;
							end
							ph = PH_DONE;
						end
					end
					PH_DONE: begin
					end
				endcase
				// a second group in the same character always carries zero digits
				if (do_add) begin
					if (!addv) begin
						addv = 1'b1;
						addp = pend;
						addc = gcode;
						addn = neg;
					end
					ucode = gcode;
					pend  = '0;
					dseen = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			pend_q  <= '0;
			dseen_q <= 1'b0;
			ucode_q <= UC_ONE;
			neg_q   <= 1'b0;
			cnt_q   <= '0;
			fail_q  <= 1'b0;
			zchk_q  <= 1'b0;
		end else if (en && v_s1) begin
			if (eot) begin
				phase_q <= PH_START;
				pend_q  <= '0;
				dseen_q <= 1'b0;
				ucode_q <= UC_ONE;
				neg_q   <= 1'b0;
				cnt_q   <= '0;
				fail_q  <= 1'b0;
				zchk_q  <= 1'b0;
			end else begin
				phase_q <= ph;
				pend_q  <= pend;
				dseen_q <= dseen;
				ucode_q <= ucode;
				neg_q   <= neg;
				cnt_q   <= cnt;
				fail_q  <= fl;
				zchk_q  <= zc;
			end
		end
	end

	// small multiple of the unit
	always_comb begin
		unique case (code_s2)
			UC_MIN:  prod_a = pend_s2 * K_MIN;
			UC_H:    prod_a = pend_s2 * K_HOUR;
			UC_D:    prod_a = pend_s2 * K_DAY;
			default: prod_a = pend_s2;
		endcase
	end

	// second-based factor
	always_comb begin
		unique case (code_s3)
			UC_ONE:                  prod_b = prod_s3;
			UC_NS:                   prod_b = prod_s3 * F_NS;
			UC_US:                   prod_b = prod_s3 * F_US;
			UC_MS:                   prod_b = prod_s3 * F_MS;
			UC_S, UC_MIN, UC_H, UC_D: prod_b = prod_s3 * UNITS_PER_SECOND;
			default:                 prod_b = prod_s3;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_v_s2 <= 1'b0;
			grp_v_s3 <= 1'b0;
			grp_v_s4 <= 1'b0;
			res_v_s2 <= 1'b0;
			res_v_s3 <= 1'b0;
			res_v_s4 <= 1'b0;
		end else if (en) begin
			grp_v_s2 <= v_s1 && addv;
			grp_v_s3 <= grp_v_s2;
			grp_v_s4 <= grp_v_s3;
			res_v_s2 <= eot;
			res_v_s3 <= res_v_s2;
			res_v_s4 <= res_v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pend_s2     <= addp;
			code_s2     <= addc;
			neg_s2      <= addn;
			res_s2.cnt  <= cnt;
			res_s2.fail <= fl;
			res_s2.zchk <= zc;
			prod_s3     <= prod_a;
			code_s3     <= code_s2;
			neg_s3      <= neg_s2;
			res_s3      <= res_s2;
			prod_s4     <= prod_b;
			neg_s4      <= neg_s3;
			res_s4      <= res_s3;
		end
	end

	// negation folded into the add as invert plus carry in
	assign sum = total_q
		+ (grp_v_s4 ? (prod_s4 ^ {64{neg_s4}}) : 64'd0)
		+ {63'd0, grp_v_s4 && neg_s4};
	assign res_fail = res_s4.fail || (res_s4.zchk && sum == 64'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (en) begin
			total_q <= res_v_s4 ? 64'd0 : sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en && res_v_s4) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en && res_v_s4) begin
			out_time_q <= res_fail ? 64'd0 : sum;
			out_len_q  <= res_fail ? 8'd0 : 8'(res_s4.cnt);
			out_err_q  <= res_fail;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {out_len_q, out_time_q};
	assign m_tuser  = out_err_q;

`ifndef NO_ASSERTIONS
	a_stall_only_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		!en |-> res_v_s4 && out_v_q)
		else $error("input stalled without a waiting result");

	a_total_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		en && res_v_s4 |=> total_q == 64'd0)
		else $error("running total not cleared after result");

	a_scanner_restart: assert property (@(posedge clk) disable iff (!arst_n)
		en && eot |=> phase_q == PH_START && cnt_q == '0 && !fail_q)
		else $error("scanner not restarted after end of text");

	a_fail_is_done: assert property (@(posedge clk) disable iff (!arst_n)
		fail_q |-> phase_q == PH_DONE)
		else $error("failure flag outside done phase");

	a_error_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == 72'd0)
		else $error("error result with nonzero fields");
`endif

endmodule
